>>> hw/rtl/nbm_pkg.sv
// nbm_pkg: shared types and constants for the mod-12289 ntt butterfly core
// holds the request and response beat layouts, mode codes and barrett constants
// no dependencies
package nbm_pkg;

   localparam logic [13:0] Q             = 14'd12289;
   localparam logic [15:0] BARRETT_MUL   = 16'd43687;
   localparam int          BARRETT_SHIFT = 29;

   typedef enum logic [1:0] {
      MODE_FWD = 2'd0,
      MODE_INV = 2'd1,
      MODE_PNT = 2'd2,
      MODE_BAD = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [13:0] first_coef;
      logic [13:0] second_coef;
      logic [13:0] twiddle;
   } req_type;

   typedef struct packed {
      logic [13:0] upper_result;
      logic [13:0] lower_result;
      logic        range_error;
   } rsp_type;

   // per-stage load enables of the multiply and reduce pipe
   typedef struct packed {
      logic prod;
      logic est;
      logic rem;
      logic red;
   } mm_en_type;

endpackage

>>> hw/rtl/ntt_butterfly_mod_q_core.sv
// Butterfly unit for the number-theoretic transform modulo 12289: forward
// Cooley-Tukey (x+yw, x-yw), inverse Gentleman-Sande (x+y, (x-y)w) or pointwise
// product xw, with barrett reduction and an error flag that zeroes the results
// for out-of-range operands or mode 3. A beat passes through each stage register
// in turn into the response register; a new beat is accepted every cycle unless
// a response stall has filled the pipe. The six pipeline stages (operand prep,
// product, quotient estimate, remainder, conditional subtract, final add and
// subtract) each hold a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so gaps close up and beats keep being accepted while a
// response waits under stall until the pipe is full. Depends on nbm_pkg and
// nbm_modmul.
module ntt_butterfly_mod_q_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  nbm_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output nbm_pkg::rsp_type rsp_payload
);
   import nbm_pkg::*;

   localparam int NSTG = 6;

   typedef struct packed {
      mode_type    mode;
      logic [13:0] x;
      logic        err;
      logic [13:0] up;
   } side_type;

   function automatic logic [13:0] mod_add(input logic [13:0] a, input logic [13:0] b);
      logic [14:0] s;
      s = 15'(a) + 15'(b);
      if (s >= 15'(Q)) begin
         s = s - 15'(Q);
      end
      return s[13:0];
   endfunction

   function automatic logic [13:0] mod_sub(input logic [13:0] a, input logic [13:0] b);
      logic [14:0] d;
      if (a >= b) begin
         d = 15'(a) - 15'(b);
      end else begin
         d = 15'(a) + 15'(Q) - 15'(b);
      end
      return d[13:0];
   endfunction

   logic [NSTG:1] vld_ff, vld_in;
   logic [NSTG:1] en;
   side_type      side_ff [1:5];
   side_type      side_in;
   logic [13:0]   a_ff, a_in;
   logic [13:0]   b_ff;
   logic [13:0]   mm_res;
   mm_en_type     mm_en;
   rsp_type       rsp_ff, rsp_in;
   logic          bad;

   // stage enables, back to front
   always_comb begin
      en[NSTG] = !vld_ff[NSTG] || !rsp_stall;
      for (int i = NSTG - 1; i >= 1; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[1] = req_valid;
      for (int i = 2; i <= NSTG; i++) begin
         vld_in[i] = vld_ff[i-1];
      end
   end

   assign req_stall = !en[1];

   // operand prep and range check
   always_comb begin
      bad = (req_payload.first_coef >= Q) || (req_payload.twiddle >= Q) ||
            ((mode_type'(req_payload.mode) != MODE_PNT) &&
             (req_payload.second_coef >= Q)) ||
            (mode_type'(req_payload.mode) == MODE_BAD);
      side_in.mode = mode_type'(req_payload.mode);
      side_in.x    = req_payload.first_coef;
      side_in.err  = bad;
      side_in.up   = mod_add(req_payload.first_coef, req_payload.second_coef);
      unique case (mode_type'(req_payload.mode))
         MODE_FWD: a_in = req_payload.second_coef;
         MODE_INV: a_in = mod_sub(req_payload.first_coef, req_payload.second_coef);
         MODE_PNT: a_in = req_payload.first_coef;
         default:  a_in = req_payload.first_coef;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 1; i <= NSTG; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         side_ff[1] <= side_in;
         a_ff       <= a_in;
         b_ff       <= req_payload.twiddle;
      end
      for (int i = 2; i <= 5; i++) begin
         if (en[i]) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
      if (en[NSTG]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign mm_en.prod = en[2];
   assign mm_en.est  = en[3];
   assign mm_en.rem  = en[4];
   assign mm_en.red  = en[5];

   nbm_modmul u_modmul (
      .clock (clock),
      .en    (mm_en),
      .a     (a_ff),
      .b     (b_ff),
      .res   (mm_res)
   );

   // final combine
   always_comb begin
      rsp_in.range_error = side_ff[5].err;
      unique case (side_ff[5].mode)
         MODE_FWD: begin
            rsp_in.upper_result = mod_add(side_ff[5].x, mm_res);
            rsp_in.lower_result = mod_sub(side_ff[5].x, mm_res);
         end
         MODE_INV: begin
            rsp_in.upper_result = side_ff[5].up;
            rsp_in.lower_result = mm_res;
         end
         MODE_PNT: begin
            rsp_in.upper_result = mm_res;
            rsp_in.lower_result = '0;
         end
         default: begin
            rsp_in.upper_result = '0;
            rsp_in.lower_result = '0;
         end
      endcase
      if (side_ff[5].err) begin
         rsp_in.upper_result = '0;
         rsp_in.lower_result = '0;
      end
   end

   assign rsp_valid   = vld_ff[NSTG];
   assign rsp_payload = rsp_ff;

endmodule

>>> hw/rtl/nbm_modmul.sv
// nbm_modmul: four-stage barrett modular multiplier, modulus 12289
// product, quotient estimate, remainder, final conditional subtract
// depends on nbm_pkg
module nbm_modmul (
   input  logic               clock,
   input  nbm_pkg::mm_en_type en,
   input  logic [13:0]        a,
   input  logic [13:0]        b,
   output logic [13:0]        res
);
   import nbm_pkg::*;

   logic [27:0] prod_ff, prod_in;
   logic [27:0] prod2_ff;
   logic [14:0] est_ff, est_in;
   logic [43:0] est_full;
   logic [14:0] rem_ff, rem_in;
   logic [27:0] rem_full;
   logic [13:0] red_ff, red_in;

   always_comb begin
      prod_in  = 28'(a) * 28'(b);
      est_full = 44'(prod_ff) * 44'(BARRETT_MUL);
      est_in   = est_full[43:BARRETT_SHIFT];
      rem_full = prod2_ff - 28'(est_ff) * 28'(Q);
      rem_in   = rem_full[14:0];
      if (rem_ff >= 15'(Q)) begin
         red_in = 14'(rem_ff - 15'(Q));
      end else begin
         red_in = rem_ff[13:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en.prod) begin
         prod_ff <= prod_in;
      end
      if (en.est) begin
         est_ff   <= est_in;
         prod2_ff <= prod_ff;
      end
      if (en.rem) begin
         rem_ff <= rem_in;
      end
      if (en.red) begin
         red_ff <= red_in;
      end
   end

   assign res = red_ff;

endmodule

>>> hw/rtl/nbm_checker.sv
// nbm_checker: port-level assertions for the ntt butterfly core
// bound to ntt_butterfly_mod_q_core; depends on nbm_pkg
module nbm_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input nbm_pkg::rsp_type rsp_payload
);
   import nbm_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response beat changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.range_error |->
         rsp_payload.upper_result == '0 && rsp_payload.lower_result == '0)
      else $error("error beat carries nonzero results");

   a_reduced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.upper_result < Q && rsp_payload.lower_result < Q)
      else $error("result not fully reduced");

   a_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while response side is free");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind ntt_butterfly_mod_q_core nbm_checker u_nbm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking bench for ntt_butterfly_mod_q_core, butterflies mod 12289
// predicts each result beat with its own barrett arithmetic and checks them in order
// depends on nbm_pkg and the core rtl only
module tb_top;
   import nbm_pkg::*;

   localparam int MAX_RES     = 12288;
   localparam int HOLD_LEN    = 200;
   localparam int IDLE_LIMIT  = 4000;
   localparam int DRAIN_TAIL  = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   rsp_type butterfly_due[$];
   rsp_type want;
   int      fail_count = 0;
   int      beats_taken = 0;
   int      results_checked = 0;
   int      flagged_beats = 0;
   int      fwd_beats = 0;
   int      inv_beats = 0;
   int      pnt_beats = 0;
   int      input_stall_cycles = 0;
   int      idle_cycles = 0;
   int      stall_left = 0;
   int      stall_roll;
   int      hold_token = 0;
   int      hold_taken = 0;
   bit      quiet_traffic = 1'b0;

   ntt_butterfly_mod_q_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic logic [13:0] barrett_mul(logic [13:0] a, logic [13:0] b);
      logic [63:0] prod;
      logic [63:0] quot;
      logic [63:0] rem;
      prod = 64'(a) * 64'(b);
      quot = (prod * 64'(BARRETT_MUL)) >> BARRETT_SHIFT;
      rem = prod - quot * 64'(Q);
      if (rem >= 64'(Q)) begin
         rem = rem - 64'(Q);
      end
      return rem[13:0];
   endfunction

   function automatic logic [13:0] add_mod(logic [13:0] a, logic [13:0] b);
      logic [14:0] s;
      s = 15'(a) + 15'(b);
      if (s >= 15'(Q)) begin
         s = s - 15'(Q);
      end
      return s[13:0];
   endfunction

   function automatic logic [13:0] sub_mod(logic [13:0] a, logic [13:0] b);
      logic [14:0] d;
      d = (a >= b) ? 15'(a) - 15'(b) : 15'(a) + 15'(Q) - 15'(b);
      return d[13:0];
   endfunction

   function automatic rsp_type butterfly_expect(req_type b);
      rsp_type    r;
      logic [13:0] v;
      mode_type   m;
      r = '0;
      m = mode_type'(b.mode);
      if (m == MODE_BAD) begin
         r.range_error = 1'b1;
      end else if (b.first_coef >= Q || b.twiddle >= Q ||
                   (m != MODE_PNT && b.second_coef >= Q)) begin
         r.range_error = 1'b1;
      end else begin
         case (m)
            MODE_FWD: begin
               v = barrett_mul(b.second_coef, b.twiddle);
               r.upper_result = add_mod(b.first_coef, v);
               r.lower_result = sub_mod(b.first_coef, v);
            end
            MODE_INV: begin
               r.upper_result = add_mod(b.first_coef, b.second_coef);
               r.lower_result = barrett_mul(sub_mod(b.first_coef, b.second_coef), b.twiddle);
            end
            default: begin
               r.upper_result = barrett_mul(b.first_coef, b.twiddle);
            end
         endcase
      end
      return r;
   endfunction

   function automatic void check_field(string name, int exp_val, int got_val);
      if (exp_val != got_val) begin
         fail_count++;
         $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_val, got_val);
      end
   endfunction

   // scoreboard, prediction and idle watch
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_checked++;
            if (butterfly_due.size() == 0) begin
               fail_count++;
               $display("%0t unexpected result beat upper %0d lower %0d error %0b", $time,
                        rsp_payload.upper_result, rsp_payload.lower_result,
                        rsp_payload.range_error);
            end else begin
               want = butterfly_due.pop_front();
               check_field("upper_result", int'(want.upper_result),
                           int'(rsp_payload.upper_result));
               check_field("lower_result", int'(want.lower_result),
                           int'(rsp_payload.lower_result));
               check_field("range_error", int'(want.range_error),
                           int'(rsp_payload.range_error));
            end
         end
         if (req_valid && !req_stall) begin
            want = butterfly_expect(req_payload);
            butterfly_due.push_back(want);
            beats_taken++;
            if (want.range_error) begin
               flagged_beats++;
            end else begin
               case (mode_type'(req_payload.mode))
                  MODE_FWD: fwd_beats++;
                  MODE_INV: inv_beats++;
                  default:  pnt_beats++;
               endcase
            end
         end
         if (req_valid && req_stall) begin
            input_stall_cycles++;
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      if (hold_token != hold_taken) begin
         hold_taken <= hold_token;
         stall_left <= HOLD_LEN - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (quiet_traffic) begin
         rsp_stall <= 1'b0;
      end else begin
         stall_roll = $urandom_range(0, 99);
         if (stall_roll < 65) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b1;
            stall_left <= (stall_roll < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
         end
      end
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
      end
      $display("%0t timeout with %0d results outstanding", $time, butterfly_due.size());
      $display("== FAIL ==");
      $finish;
   end

   function automatic int sender_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (quiet_traffic || roll < 60) begin
         return 0;
      end else if (roll < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 40);
   endfunction

   task automatic send_beat(req_type beat);
      int gap;
      req_valid <= 1'b1;
      req_payload <= beat;
      do begin
         @(posedge clock);
      end while (req_stall);
      gap = sender_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic park_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      park_sender();
      while (butterfly_due.size() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic req_type make_beat(mode_type m, int x, int y, int w);
      req_type b;
      b.mode = m;
      b.first_coef = 14'(x);
      b.second_coef = 14'(y);
      b.twiddle = 14'(w);
      return b;
   endfunction

   function automatic logic [13:0] pick_coef();
      int roll;
      roll = $urandom_range(0, 19);
      case (roll)
         0: return 14'd0;
         1: return 14'd1;
         2: return 14'(MAX_RES);
         3: return 14'(MAX_RES - 1);
         default: return 14'($urandom_range(0, MAX_RES));
      endcase
   endfunction

   function automatic req_type random_beat();
      req_type b;
      int      roll;
      roll = $urandom_range(0, 99);
      b.mode = (roll < 3) ? MODE_BAD : mode_type'($urandom_range(0, 2));
      b.first_coef = pick_coef();
      b.second_coef = pick_coef();
      b.twiddle = pick_coef();
      if (roll >= 3 && roll < 13) begin
         case ($urandom_range(0, 2))
            0: b.first_coef = 14'($urandom_range(MAX_RES + 1, 16383));
            1: b.second_coef = 14'($urandom_range(MAX_RES + 1, 16383));
            default: b.twiddle = 14'($urandom_range(MAX_RES + 1, 16383));
         endcase
      end else if (roll >= 13 && roll < 16) begin
         b.first_coef = 14'($urandom_range(0, 16383));
         b.second_coef = 14'($urandom_range(0, 16383));
         b.twiddle = 14'($urandom_range(0, 16383));
      end
      return b;
   endfunction

   task automatic test_directed_corners();
      send_beat(make_beat(MODE_FWD, 0, 0, 0));
      send_beat(make_beat(MODE_FWD, MAX_RES, MAX_RES, MAX_RES));
      send_beat(make_beat(MODE_FWD, 0, MAX_RES, 1));
      send_beat(make_beat(MODE_FWD, MAX_RES, 1, MAX_RES));
      send_beat(make_beat(MODE_FWD, 1, 12287, 12287));
      send_beat(make_beat(MODE_INV, 0, 0, 0));
      send_beat(make_beat(MODE_INV, MAX_RES, MAX_RES, MAX_RES));
      send_beat(make_beat(MODE_INV, 0, MAX_RES, MAX_RES));
      send_beat(make_beat(MODE_INV, MAX_RES, 0, 1));
      send_beat(make_beat(MODE_PNT, MAX_RES, 0, MAX_RES));
      send_beat(make_beat(MODE_PNT, 0, 5, MAX_RES));
      // second coefficient is ignored in pointwise mode
      send_beat(make_beat(MODE_PNT, 1234, 16383, 4321));
      send_beat(make_beat(MODE_PNT, 100, MAX_RES + 1, 7));
      // out-of-range operands
      send_beat(make_beat(MODE_FWD, MAX_RES + 1, 5, 5));
      send_beat(make_beat(MODE_FWD, 5, MAX_RES + 1, 5));
      send_beat(make_beat(MODE_INV, 5, 5, MAX_RES + 1));
      send_beat(make_beat(MODE_INV, 16383, 16383, 16383));
      send_beat(make_beat(MODE_PNT, 16383, 0, 3));
      send_beat(make_beat(MODE_PNT, 3, 0, 16383));
      // bad mode
      send_beat(make_beat(MODE_BAD, 10, 20, 30));
      send_beat(make_beat(MODE_BAD, 16383, 16383, 16383));
      send_beat(make_beat(MODE_BAD, 0, 0, 0));
      wait_drained();
   endtask

   task automatic test_random_stream(int count);
      for (int i = 0; i < count; i++) begin
         quiet_traffic = (i >= count / 2 && i < count / 2 + 150);
         send_beat(random_beat());
      end
      quiet_traffic = 1'b0;
      park_sender();
   endtask

   task automatic test_long_holdoff();
      quiet_traffic = 1'b1;
      hold_token = hold_token + 1;
      for (int i = 0; i < 60; i++) begin
         send_beat(random_beat());
      end
      quiet_traffic = 1'b0;
      wait_drained();
   endtask

   task automatic test_drain_pause();
      for (int i = 0; i < 30; i++) begin
         send_beat(random_beat());
      end
      wait_drained();
      for (int i = 0; i < 30; i++) begin
         send_beat(random_beat());
      end
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_corners();
      test_random_stream(1350);
      test_long_holdoff();
      test_drain_pause();
      wait_drained();
      quiet_traffic = 1'b1;
      repeat (DRAIN_TAIL) @(posedge clock);
      $display("covered %0d beats: %0d forward, %0d inverse, %0d pointwise, %0d flagged",
               beats_taken, fwd_beats, inv_beats, pnt_beats, flagged_beats);
      $display("checked %0d results, input held off for %0d cycles", results_checked,
               input_stall_cycles);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
